// ===== hw/rtl/sgbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbm_pkg
// Shared types, constants and helper functions of the mirrored separable blur.
// ----------------------------------------------------------------------------
package sgbm_pkg;

   // Store geometry and kernel limits
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int MAX_RADIUS = 3;

   // Field and datapath widths
   localparam int POS_W   = 6;                               // row / col field
   localparam int SIZE_W  = 7;                               // height / width register
   localparam int IDX_W   = SIZE_W + 1;                      // signed index before folding
   localparam int PIX_W   = 16;
   localparam int COEF_W  = 16;
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int DIST_W  = RAD_W + 1;                       // signed tap offset
   localparam int PROD_W  = PIX_W + COEF_W;
   localparam int ACC_W   = PROD_W + $clog2(2 * MAX_RADIUS + 1);
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int NUM_COEF = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RND_SHIFT = 16;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_HEIGHT = 3'd0,
      CSR_IMAGE_WIDTH  = 3'd1,
      CSR_HALF_WIDTH   = 3'd2,
      CSR_CENTER_COEF  = 3'd3,
      CSR_COEF_ONE     = 3'd4,
      CSR_COEF_TWO     = 3'd5,
      CSR_COEF_THREE   = 3'd6
   } sgbm_csr_type;

   // Register reset values
   localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(64);
   localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(64);
   localparam logic [1:0]        RST_HALF   = 2'd3;
   localparam logic [COEF_W-1:0] RST_COEF0  = COEF_W'(21843);
   localparam logic [COEF_W-1:0] RST_COEF1  = COEF_W'(15438);
   localparam logic [COEF_W-1:0] RST_COEF2  = COEF_W'(5448);
   localparam logic [COEF_W-1:0] RST_COEF3  = COEF_W'(960);

   // Request modes
   localparam logic MODE_STORE = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [PIX_W-1:0] pixel;
   } sgbm_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] blurred_value;
      logic             out_of_range;
   } sgbm_rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VREAD,
      ST_VWAIT,
      ST_VLAST,
      ST_HMUL,
      ST_HFIN,
      ST_OUT
   } sgbm_state_type;

   // Sequencer strobes to the datapath
   typedef struct packed {
      logic load;        // latch a fetch and clear the accumulators
      logic issue;       // store read for the current tap
      logic horiz_mul;   // shared multiplier takes the vertical result
      logic rsp_oor;     // out-of-range fetch answered from idle
      logic rsp_done;    // blurred result goes out
   } sgbm_ctrl_type;

   // Mirror an index into [0, size-1] without repeating the edge pixel.
   // Sizes 2 and 3 fold with period 2 and 4, taken as a mask.
   function automatic logic [POS_W-1:0] fold_idx(logic signed [IDX_W-1:0] idx,
                                                 logic [SIZE_W-1:0] size);
      logic signed [IDX_W-1:0] last;
      logic signed [IDX_W-1:0] m;
      last = signed'({1'b0, size}) - IDX_W'(1);
      m    = idx;
      if (size <= SIZE_W'(1)) begin
         m = '0;
      end else if (size == SIZE_W'(2)) begin
         m = IDX_W'({1'b0, idx[0]});
      end else if (size == SIZE_W'(3)) begin
         m = IDX_W'({1'b0, idx[1:0]});
         if (m > IDX_W'(2)) begin
            m = IDX_W'(4) - m;
         end
      end else if (idx < 0) begin
         m = -idx;
      end else if (idx > last) begin
         m = (last <<< 1) - idx;
      end
      return m[POS_W-1:0];
   endfunction

   // Round half up from Q.16 and saturate to 16 bits
   function automatic logic [PIX_W-1:0] round_sat16(logic [ACC_W-1:0] acc);
      logic [ACC_W:0] sum;
      logic [ACC_W-RND_SHIFT:0] q;
      sum = {1'b0, acc} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
      q   = sum[ACC_W:RND_SHIFT];
      if (q > (ACC_W-RND_SHIFT+1)'({PIX_W{1'b1}})) begin
         return {PIX_W{1'b1}};
      end
      return q[PIX_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/sgbm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/separable_gaussian_blur_mirror_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_gaussian_blur_mirror_top
// Pixel store with a mirrored-edge separable blur fetched one pixel at a time.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a clock edge with start high and busy low. A store
//   item (mode 0) writes its pixel in that same edge if it lies inside the
//   configured size, raises no result and leaves the block ready in the
//   next cycle. A fetch item (mode 1) outside the configured size answers in
//   the next cycle with value 0 and the out_of_range flag, and stays ready.
//   A fetch inside the image walks the kernel through one shared 16x16
//   multiplier fed by the single read port of the pixel store: per column
//   of the kernel, 2r+1 reads, the wait states ST_VWAIT and ST_VLAST and one
//   horizontal multiply, with r the kernel radius. busy stays high through
//   ST_OUT and rsp_valid pulses for one cycle as busy falls. The receiver
//   cannot stall: rsp_data is valid only while rsp_valid is high. Registers
//   are written through csr_we/csr_index/csr_wdata by the user only while
//   idle; the block itself does not enforce it. Reset restores the register
//   defaults and idles the sequencer; the pixel store is not cleared and each
//   pixel must be stored before it is fetched.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_mirror_top
   import sgbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sgbm_req_type          req_data,
   output logic                  rsp_valid,
   output sgbm_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [SIZE_W-1:0] height_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [1:0]        half_ff;
   logic [COEF_W-1:0] coef_ff [NUM_COEF];

   // Sequencer
   sgbm_state_type state_ff, state_in;
   sgbm_ctrl_type  ctrl;

   // Datapath
   logic [POS_W-1:0]         row_ff, col_ff;
   logic signed [DIST_W-1:0] dr_ff, dr_in, dc_ff, dc_in;
   logic [COEF_W-1:0]        w_rd_ff;
   logic                     rd_v_ff, mul_v_ff, hacc_v_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [ACC_W-1:0]         vacc_ff, vacc_in, hacc_ff, hacc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sgbm_rsp_type             rsp_ff, rsp_in;

   logic [SIZE_W-1:0]        eff_h, eff_w;
   logic [RAD_W-1:0]         rad;
   logic signed [DIST_W-1:0] rad_pos, rad_neg;
   logic                     in_image, accept, last_row_tap, last_col_tap;
   logic [POS_W-1:0]         mr, mc;
   logic [ADDR_W-1:0]        rd_addr, wr_addr;
   logic                     wr_en;
   logic [PIX_W-1:0]         rd_data;
   logic [PIX_W-1:0]         mul_a;
   logic [COEF_W-1:0]        mul_b;
   logic [COEF_W-1:0]        w_row, w_col;

   // Tap weight by distance from the center
   function automatic logic [COEF_W-1:0] tap_weight(logic signed [DIST_W-1:0] d,
                                                    logic [COEF_W-1:0] c0,
                                                    logic [COEF_W-1:0] c1,
                                                    logic [COEF_W-1:0] c2,
                                                    logic [COEF_W-1:0] c3);
      logic signed [DIST_W-1:0] a;
      logic [RAD_W-1:0]         mag;
      a   = (d < 0) ? -d : d;
      mag = a[RAD_W-1:0];
      case (mag)
         2'd0:    return c0;
         2'd1:    return c1;
         2'd2:    return c2;
         2'd3:    return c3;
         default: return '0;
      endcase
   endfunction

   // Effective sizes and radius
   assign eff_h   = (height_ff > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : height_ff;
   assign eff_w   = (width_ff > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : width_ff;
   assign rad     = (half_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : half_ff;
   assign rad_pos = signed'({1'b0, rad});
   assign rad_neg = -rad_pos;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_image = ({1'b0, req_data.row} < eff_h) && ({1'b0, req_data.col} < eff_w);
   assign last_row_tap = (dr_ff == rad_pos);
   assign last_col_tap = (dc_ff == rad_pos);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff  <= RST_HEIGHT;
         width_ff   <= RST_WIDTH;
         half_ff    <= RST_HALF;
         coef_ff[0] <= RST_COEF0;
         coef_ff[1] <= RST_COEF1;
         coef_ff[2] <= RST_COEF2;
         coef_ff[3] <= RST_COEF3;
      end else if (csr_we) begin
         case (sgbm_csr_type'(csr_index))
            CSR_IMAGE_HEIGHT: height_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_HALF_WIDTH:   half_ff    <= csr_wdata[1:0];
            CSR_CENTER_COEF:  coef_ff[0] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_ONE:     coef_ff[1] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_TWO:     coef_ff[2] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_THREE:   coef_ff[3] <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.mode == MODE_FETCH) && in_image) begin
               state_in = ST_VREAD;
            end
         end
         ST_VREAD: begin
            if (last_row_tap) begin
               state_in = ST_VWAIT;
            end
         end
         ST_VWAIT: state_in = ST_VLAST;
         ST_VLAST: state_in = ST_HMUL;
         ST_HMUL:  state_in = last_col_tap ? ST_HFIN : ST_VREAD;
         ST_HFIN:  state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer strobes
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.load    = accept && (req_data.mode == MODE_FETCH) && in_image;
            ctrl.rsp_oor = accept && (req_data.mode == MODE_FETCH) && !in_image;
         end
         ST_VREAD: ctrl.issue     = 1'b1;
         ST_HMUL:  ctrl.horiz_mul = 1'b1;
         ST_OUT:   ctrl.rsp_done  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Tap counters: rows run inside each column
   always_comb begin
      dr_in = dr_ff;
      dc_in = dc_ff;
      if (ctrl.load) begin
         dr_in = rad_neg;
         dc_in = rad_neg;
      end else if (ctrl.issue && !last_row_tap) begin
         dr_in = dr_ff + DIST_W'(1);
      end else if (ctrl.horiz_mul && !last_col_tap) begin
         dr_in = rad_neg;
         dc_in = dc_ff + DIST_W'(1);
      end
   end

   // Store addressing with mirrored edges
   assign mr      = fold_idx(signed'({2'b00, row_ff}) + IDX_W'(dr_ff), eff_h);
   assign mc      = fold_idx(signed'({2'b00, col_ff}) + IDX_W'(dc_ff), eff_w);
   assign rd_addr = ADDR_W'(mr) * ADDR_W'(MAX_COLS) + ADDR_W'(mc);
   assign wr_addr = ADDR_W'(req_data.row) * ADDR_W'(MAX_COLS) + ADDR_W'(req_data.col);
   assign wr_en   = accept && (req_data.mode == MODE_STORE) && in_image;

   sgbm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared multiplier operands: store data in the vertical pass,
   // the rounded column sum in the horizontal step
   assign w_row = tap_weight(dr_ff, coef_ff[0], coef_ff[1], coef_ff[2], coef_ff[3]);
   assign w_col = tap_weight(dc_ff, coef_ff[0], coef_ff[1], coef_ff[2], coef_ff[3]);
   assign mul_a = ctrl.horiz_mul ? round_sat16(vacc_ff) : rd_data;
   assign mul_b = ctrl.horiz_mul ? w_col : w_rd_ff;

   // Accumulators
   always_comb begin
      vacc_in = vacc_ff;
      hacc_in = hacc_ff;
      if (ctrl.load || ctrl.horiz_mul) begin
         vacc_in = '0;
      end else if (mul_v_ff) begin
         vacc_in = vacc_ff + ACC_W'(prod_ff);
      end
      if (ctrl.load) begin
         hacc_in = '0;
      end else if (hacc_v_ff) begin
         hacc_in = hacc_ff + ACC_W'(prod_ff);
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = ctrl.rsp_oor || ctrl.rsp_done;
      rsp_in       = rsp_ff;
      if (ctrl.rsp_oor) begin
         rsp_in.blurred_value = '0;
         rsp_in.out_of_range  = 1'b1;
      end else if (ctrl.rsp_done) begin
         rsp_in.blurred_value = round_sat16(hacc_ff);
         rsp_in.out_of_range  = 1'b0;
      end
   end

   // Pipeline valids and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         hacc_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff      <= ctrl.issue;
         mul_v_ff     <= rd_v_ff;
         hacc_v_ff    <= ctrl.horiz_mul;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         row_ff <= req_data.row;
         col_ff <= req_data.col;
      end
      dr_ff   <= dr_in;
      dc_ff   <= dc_in;
      w_rd_ff <= w_row;
      if (rd_v_ff || ctrl.horiz_mul) begin
         prod_ff <= mul_a * mul_b;
      end
      vacc_ff <= vacc_in;
      hacc_ff <= hacc_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
